[src/rse_pkg.sv]
`timescale 1ns / 1ps
package rse_pkg;

  localparam int DATA_W        = 24;
  localparam int FW_W          = 12;
  localparam int FH_W          = 16;
  localparam int GAIN_W        = 10;
  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [FW_W-1:0]   FW_RESET   = 12'd640;
  localparam logic [FH_W-1:0]   FH_RESET   = 16'd480;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 10'd410;  // 0.40 in 1/1024 units

  // floor(sqrt(x)) >= 255 from here on
  localparam logic [15:0] SQRT_SAT = 16'd65025;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SHARPEN_MODE = 2'd2,
    REG_SHARPEN_GAIN = 2'd3
  } reg_idx_t;

  // what the front hands to the back for one item
  typedef struct packed {
    logic is_pix;    // pixel write (else drain)
    logic emit;      // a result follows
    logic interior;  // Sobel path, else border rule
    logic use_mid;   // border pixel lives in the middle store
    logic last;      // last pixel of the frame
  } job_flags_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SHIFT,
    BK_SQX,
    BK_SQY,
    BK_ROOT,
    BK_ORIG_RD,
    BK_ORIG,
    BK_MIX,
    BK_PUSH
  } back_state_t;

endpackage

[src/rse_fifo.sv]
`timescale 1ns / 1ps
module rse_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW:0]  wp_r, rp_r;

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW-1:0] == rp_r[AW-1:0]) && (wp_r[AW] != rp_r[AW]);
  assign dout  = mem[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r[AW-1:0]] <= din;
  end

endmodule

[src/rse_front.sv]
`timescale 1ns / 1ps
module rse_front import rse_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              restart,
  input  logic [FW_W-1:0]   frame_width,
  input  logic [FH_W-1:0]   frame_height,
  input  logic              in_valid,
  input  logic              op,
  input  logic [DATA_W-1:0] pixel,
  output logic              job_push,
  output job_flags_t        job_flags,
  output logic [DATA_W-1:0] job_pixel,
  output logic [CW-1:0]     job_wcol,
  output logic [CW-1:0]     job_ocol
);
  localparam int PW  = $clog2(MAX_WIDTH + 3);
  localparam int EW  = (PW > FW_W) ? PW : FW_W;
  localparam int CMP = EW + 1;

  logic [CW-1:0]   col_r, col_nxt, ocol_r, ocol_nxt;
  logic [FH_W-1:0] row_r, row_nxt, orow_r, orow_nxt;
  logic [PW-1:0]   pend_r, pend_nxt;

  logic [CMP-1:0]  w_e;
  logic [FH_W-1:0] h_e;

  logic            wrap;
  logic [CW-1:0]   col0, ocol0;
  logic [FH_W-1:0] row0, orow0;
  logic [PW-1:0]   pend0;
  logic [CMP-1:0]  col1, pend1, oc1;

  always_comb begin
    w_e = CMP'(frame_width);
    if (frame_width == '0) begin
      w_e = CMP'(1);
    end else if (w_e > CMP'(MAX_WIDTH)) begin
      w_e = CMP'(MAX_WIDTH);
    end
    h_e = (frame_height == '0) ? FH_W'(1) : frame_height;
  end

  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    pend_nxt  = pend_r;
    ocol_nxt  = ocol_r;
    orow_nxt  = orow_r;
    job_push  = 1'b0;
    job_flags = '0;
    job_pixel = pixel;
    job_wcol  = col_r;
    job_ocol  = ocol_r;

    // a pixel after a complete frame opens a new one
    wrap  = !op && ((row_r >= h_e) || (CMP'(col_r) >= w_e));
    col0  = wrap ? '0 : col_r;
    row0  = wrap ? '0 : row_r;
    pend0 = wrap ? '0 : pend_r;
    ocol0 = wrap ? '0 : ocol_r;
    orow0 = wrap ? '0 : orow_r;
    col1  = CMP'(col0) + CMP'(1);
    pend1 = CMP'(pend0) + CMP'(1);
    oc1   = CMP'(ocol0) + CMP'(1);

    job_flags.last = (({1'b0, orow0} + 17'd1) == {1'b0, h_e}) && (oc1 == w_e);
    job_ocol       = ocol0;

    if (in_valid) begin
      if (!op) begin
        job_push           = 1'b1;
        job_wcol           = col0;
        job_flags.is_pix   = 1'b1;
        job_flags.emit     = pend1 > (w_e + CMP'(1));
        job_flags.use_mid  = pend1 <= w_e;
        job_flags.interior = (orow0 != '0) && (({1'b0, orow0} + 17'd2) <= {1'b0, h_e}) &&
                             (ocol0 != '0) && ((CMP'(ocol0) + CMP'(2)) <= w_e);
        if (col1 >= w_e) begin
          col_nxt = '0;
          row_nxt = row0 + 1'b1;
        end else begin
          col_nxt = col1[CW-1:0];
          row_nxt = row0;
        end
        if (job_flags.emit) begin
          pend_nxt = pend0;
          if (oc1 >= w_e) begin
            ocol_nxt = '0;
            orow_nxt = orow0 + 1'b1;
          end else begin
            ocol_nxt = oc1[CW-1:0];
            orow_nxt = orow0;
          end
        end else begin
          pend_nxt = pend1[PW-1:0];
          ocol_nxt = ocol0;
          orow_nxt = orow0;
        end
      end else if ((row_r >= h_e) && (pend_r != '0)) begin
        // drain: always a border pixel, no restart
        job_push          = 1'b1;
        job_flags.emit    = 1'b1;
        job_flags.use_mid = CMP'(pend_r) <= w_e;
        pend_nxt          = pend_r - 1'b1;
        if (oc1 >= w_e) begin
          ocol_nxt = '0;
          orow_nxt = orow_r + 1'b1;
        end else begin
          ocol_nxt = oc1[CW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r  <= '0;
      row_r  <= '0;
      pend_r <= '0;
      ocol_r <= '0;
      orow_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pend_r <= pend_nxt;
      ocol_r <= ocol_nxt;
      orow_r <= orow_nxt;
    end
  end

endmodule

[src/rse_back.sv]
`timescale 1ns / 1ps
module rse_back import rse_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int CW        = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sharpen_mode,
  input  logic [GAIN_W-1:0] sharpen_gain,
  input  logic              job_empty,
  input  job_flags_t        job_flags,
  input  logic [DATA_W-1:0] job_pixel,
  input  logic [CW-1:0]     job_wcol,
  input  logic [CW-1:0]     job_ocol,
  output logic              job_pop,
  input  logic              res_full,
  output logic              res_push,
  output logic [DATA_W-1:0] res_pixel,
  output logic              res_last
);
  back_state_t st_r, st_nxt;

  job_flags_t        flags_r;
  logic [DATA_W-1:0] pix_r;
  logic [CW-1:0]     wcol_r, ocol_r;

  // line stores
  logic [DATA_W-1:0] upper_mem [MAX_WIDTH];
  logic [DATA_W-1:0] mid_mem   [MAX_WIDTH];
  logic [DATA_W-1:0] up_q, mid_q;
  logic [CW-1:0]     rd_addr;

  logic [DATA_W-1:0] win_r [3][3];

  // per-channel lanes
  logic [19:0] sqx_r [3];
  logic [9:0]  gy_r  [3];
  logic [15:0] rad_r [3];
  logic [9:0]  rem_r [3];
  logic [7:0]  root_r [3];
  logic [2:0]  cnt_r;

  logic [DATA_W-1:0] edge_r, orig_r, val_r;

  logic [9:0]  gx_abs [3];
  logic [9:0]  gy_abs [3];
  logic [20:0] sum_w  [3];
  logic [15:0] rad_w  [3];
  logic [11:0] rem_w  [3];
  logic [9:0]  trial  [3];
  logic [9:0]  rem_n  [3];
  logic [7:0]  root_n [3];
  logic [DATA_W-1:0] mix_w, root_cat;

  assign rd_addr = (st_r == BK_IDLE) ? job_wcol : ocol_r;

  always_ff @(posedge clk) begin
    if (st_r == BK_SHIFT) begin
      upper_mem[wcol_r] <= mid_q;
      mid_mem[wcol_r]   <= pix_r;
    end
    up_q  <= upper_mem[rd_addr];
    mid_q <= mid_mem[rd_addr];
  end

  // Sobel sums, root step and gain per channel
  always_comb begin
    logic [10:0] lx, rx, ty, by;
    logic [17:0] prod;
    logic [8:0]  sv;
    for (int ch = 0; ch < 3; ch++) begin
      lx = 11'(win_r[0][0][8*ch +: 8]) + {2'b0, win_r[1][0][8*ch +: 8], 1'b0} +
           11'(win_r[2][0][8*ch +: 8]);
      rx = 11'(win_r[0][2][8*ch +: 8]) + {2'b0, win_r[1][2][8*ch +: 8], 1'b0} +
           11'(win_r[2][2][8*ch +: 8]);
      ty = 11'(win_r[0][0][8*ch +: 8]) + {2'b0, win_r[0][1][8*ch +: 8], 1'b0} +
           11'(win_r[0][2][8*ch +: 8]);
      by = 11'(win_r[2][0][8*ch +: 8]) + {2'b0, win_r[2][1][8*ch +: 8], 1'b0} +
           11'(win_r[2][2][8*ch +: 8]);
      gx_abs[ch] = (rx >= lx) ? 10'(rx - lx) : 10'(lx - rx);
      gy_abs[ch] = (by >= ty) ? 10'(by - ty) : 10'(ty - by);

      sum_w[ch] = 21'(sqx_r[ch]) + 21'(gy_r[ch] * gy_r[ch]);
      rad_w[ch] = (sum_w[ch] >= 21'(SQRT_SAT)) ? SQRT_SAT : sum_w[ch][15:0];

      rem_w[ch] = {rem_r[ch], rad_r[ch][15:14]};
      trial[ch] = {root_r[ch], 2'b01};
      if (rem_w[ch] >= 12'(trial[ch])) begin
        rem_n[ch]  = 10'(rem_w[ch] - 12'(trial[ch]));
        root_n[ch] = {root_r[ch][6:0], 1'b1};
      end else begin
        rem_n[ch]  = rem_w[ch][9:0];
        root_n[ch] = {root_r[ch][6:0], 1'b0};
      end
      root_cat[8*ch +: 8] = root_n[ch];

      prod = sharpen_gain * edge_r[8*ch +: 8];
      sv   = 9'(orig_r[8*ch +: 8]) + 9'(prod[17:10]);
      mix_w[8*ch +: 8] = sv[8] ? 8'hFF : sv[7:0];
    end
    if (!sharpen_mode) mix_w = edge_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt    = st_r;
    job_pop   = 1'b0;
    res_push  = 1'b0;
    res_pixel = val_r;
    res_last  = flags_r.last;
    case (st_r)
      BK_IDLE: begin
        if (!job_empty) begin
          job_pop = 1'b1;
          st_nxt  = job_flags.is_pix ? BK_SHIFT : BK_ORIG_RD;
        end
      end
      BK_SHIFT: begin
        if (!flags_r.emit)         st_nxt = BK_IDLE;
        else if (flags_r.interior) st_nxt = BK_SQX;
        else                       st_nxt = BK_ORIG_RD;
      end
      BK_SQX:     st_nxt = BK_SQY;
      BK_SQY:     st_nxt = BK_ROOT;
      BK_ROOT:    if (cnt_r == '0) st_nxt = BK_MIX;
      BK_ORIG_RD: st_nxt = BK_ORIG;
      BK_ORIG:    st_nxt = BK_MIX;
      BK_MIX:     st_nxt = BK_PUSH;
      BK_PUSH: begin
        if (!res_full) begin
          res_push = 1'b1;
          st_nxt   = BK_IDLE;
        end
      end
      default:    st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win_r[i][j] <= '0;
      end
    end else if (st_r == BK_SHIFT) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= up_q;
      win_r[1][2] <= mid_q;
      win_r[2][2] <= pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      flags_r <= job_flags;
      pix_r   <= job_pixel;
      wcol_r  <= job_wcol;
      ocol_r  <= job_ocol;
    end
    case (st_r)
      BK_SQX: begin
        for (int ch = 0; ch < 3; ch++) begin
          sqx_r[ch] <= gx_abs[ch] * gx_abs[ch];
          gy_r[ch]  <= gy_abs[ch];
        end
      end
      BK_SQY: begin
        for (int ch = 0; ch < 3; ch++) begin
          rad_r[ch]  <= rad_w[ch];
          rem_r[ch]  <= '0;
          root_r[ch] <= '0;
        end
        cnt_r <= 3'd7;
      end
      BK_ROOT: begin
        for (int ch = 0; ch < 3; ch++) begin
          rad_r[ch]  <= {rad_r[ch][13:0], 2'b00};
          rem_r[ch]  <= rem_n[ch];
          root_r[ch] <= root_n[ch];
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          edge_r <= root_cat;
          orig_r <= win_r[1][1];
        end
      end
      BK_ORIG: begin
        edge_r <= flags_r.use_mid ? mid_q : up_q;
        orig_r <= flags_r.use_mid ? mid_q : up_q;
      end
      BK_MIX:  val_r <= mix_w;
      default: ;
    endcase
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> st_r == BK_IDLE)
    else $error("back not idle after reset");

  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_ROOT && cnt_r != '0) |=> st_r == BK_ROOT)
    else $error("square root left early");

  a_shift_src: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BK_SHIFT) |-> $past(st_r) == BK_IDLE)
    else $error("window shift without a fresh job");

  a_push_gate: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!res_full && $past(st_r) == BK_MIX || $past(st_r) == BK_PUSH))
    else $error("result pushed out of sequence");

endmodule

[src/rgb_sobel_edge_sharpen.sv]
`timescale 1ns / 1ps
// 3x3 Sobel edge magnitude / sharpen filter on packed RGB pixels.
// Input channel (queue style): present in_op/in_pixel_in with in_push; the item
// is taken on a clock edge with in_push high and in_full low. op 0 supplies a
// pixel in raster order, op 1 drains one pending result after the frame.
// Result channel: while out_empty is low, out_pixel_out/out_frame_last show the
// oldest result; it is taken on an edge with out_pop high.
// Results trail the input by one row plus one pixel; drains flush the rest.
// Config: APB-style, regs at 0x0 width, 0x4 height, 0x8 mode, 0xC gain.
// Writing width or height restarts the frame. Write only while idle.
// Per-item steps in the back end (one item at a time, memory port shared):
//   pixel with no result: window shift only; a pixel with a result shifts first,
//   then a border result (pixel or drain) reads a line store, an interior result
//   squares the gradients and runs the bit-serial root; both then mix and push.
// A 4-entry job queue lets the front keep accepting while the back works,
// and a 2-entry result queue holds finished items while the receiver stalls;
// a stalled receiver fills both queues, then in_full rises.
// Reset: registers go to their reset values, window and frame counters to zero.
// Line stores are not cleared; unwritten entries never reach a result.
module rgb_sobel_edge_sharpen import rse_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input item
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_op,
  input  logic [DATA_W-1:0] in_pixel_in,
  // result item
  output logic              out_empty,
  input  logic              out_pop,
  output logic [DATA_W-1:0] out_pixel_out,
  output logic              out_frame_last,
  // config
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int JW = $bits(job_flags_t) + DATA_W + 2 * CW;
  localparam int RW = DATA_W + 1;

  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic              sharpen_mode_r;
  logic [GAIN_W-1:0] sharpen_gain_r;

  reg_idx_t reg_idx;
  logic     cfg_wr, restart;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign restart = cfg_wr && (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FW_RESET;
      frame_height_r <= FH_RESET;
      sharpen_mode_r <= 1'b0;
      sharpen_gain_r <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[FH_W-1:0];
        REG_SHARPEN_MODE: sharpen_mode_r <= pwdata[0];
        REG_SHARPEN_GAIN: sharpen_gain_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = 32'(frame_height_r);
      REG_SHARPEN_MODE: prdata = 32'(sharpen_mode_r);
      REG_SHARPEN_GAIN: prdata = 32'(sharpen_gain_r);
      default:          prdata = '0;
    endcase
  end

  // front: bookkeeping and classification
  logic              in_valid, f_push;
  job_flags_t        f_flags;
  logic [DATA_W-1:0] f_pix;
  logic [CW-1:0]     f_wcol, f_ocol;

  assign in_valid = in_push && !in_full;

  rse_front #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .in_valid     (in_valid),
    .op           (in_op),
    .pixel        (in_pixel_in),
    .job_push     (f_push),
    .job_flags    (f_flags),
    .job_pixel    (f_pix),
    .job_wcol     (f_wcol),
    .job_ocol     (f_ocol)
  );

  // job queue between front and back
  logic [JW-1:0]     jq_din, jq_dout;
  logic              jq_empty, jq_pop;
  job_flags_t        b_flags;
  logic [DATA_W-1:0] b_pix;
  logic [CW-1:0]     b_wcol, b_ocol;

  assign jq_din = {f_flags, f_pix, f_wcol, f_ocol};
  assign {b_flags, b_pix, b_wcol, b_ocol} = jq_dout;

  rse_fifo #(.W(JW), .DEPTH(4)) u_jobq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .din   (jq_din),
    .full  (in_full),
    .pop   (jq_pop),
    .dout  (jq_dout),
    .empty (jq_empty)
  );

  // back: line stores, window, Sobel, root, sharpen
  logic              r_push, r_full, r_last;
  logic [DATA_W-1:0] r_pix;

  rse_back #(.MAX_WIDTH(MAX_WIDTH), .CW(CW)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .sharpen_mode (sharpen_mode_r),
    .sharpen_gain (sharpen_gain_r),
    .job_empty    (jq_empty),
    .job_flags    (b_flags),
    .job_pixel    (b_pix),
    .job_wcol     (b_wcol),
    .job_ocol     (b_ocol),
    .job_pop      (jq_pop),
    .res_full     (r_full),
    .res_push     (r_push),
    .res_pixel    (r_pix),
    .res_last     (r_last)
  );

  // result queue
  logic [RW-1:0] rq_din, rq_dout;

  assign rq_din = {r_pix, r_last};
  assign {out_pixel_out, out_frame_last} = rq_dout;

  rse_fifo #(.W(RW), .DEPTH(2)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (r_push),
    .din   (rq_din),
    .full  (r_full),
    .pop   (out_pop),
    .dout  (rq_dout),
    .empty (out_empty)
  );

endmodule
